FILE: rtl/dfst_pkg.sv
package dfst_pkg;
    localparam int MaxVertices = 32;
    localparam int MaxEdges    = 64;
    localparam int VW = $clog2(MaxVertices);
    localparam int EW = $clog2(MaxEdges);
    localparam int LW = EW + 1;   // edge link with empty flag in top bit
    localparam int SW = $clog2(MaxVertices + 1);

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_RUN   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    // commands from controller to datapath
    typedef struct packed {
        logic add_edge;     // store request edge
        logic clear_graph;
        logic run_init;     // reset colors, time, scan count, stack, root index
        logic load_root;    // try root index
        logic next_root;
        logic read_top;     // fetch top of stack and its cursor edge
        logic step;         // act on fetched top
    } dfst_cmd_t;

    typedef struct packed {
        logic roots_done;
        logic root_white;
        logic stack_empty;
        logic emits;        // step will produce a result
    } dfst_sts_t;
endpackage

FILE: rtl/dfst_datapath.sv
module dfst_datapath
    import dfst_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  dfst_cmd_t         cmd,
    output dfst_sts_t         sts,
    input  logic [5:0]        vertex_count,
    input  logic [5:0]        edge_source,
    input  logic [5:0]        edge_target,
    output logic              res_valid,
    output logic              res_kind,
    output logic [5:0]        res_vertex,
    output logic [6:0]        res_stamp,
    output logic              res_root,
    output logic [6:0]        scan_count
);
    logic [VW-1:0] dest_mem [MaxEdges];
    logic [LW-1:0] link_mem [MaxEdges];
    logic [LW-1:0] head_reg [MaxVertices];
    logic [EW-1:0] tail_reg [MaxVertices];
    logic [VW-1:0] stk_v_reg [MaxVertices];
    logic [LW-1:0] stk_c_reg [MaxVertices];
    logic [MaxVertices-1:0] visited_reg;
    logic [LW-1:0] edge_total_reg;
    logic [SW-1:0] depth_reg;
    logic [6:0]    time_reg;
    logic [6:0]    scan_reg;
    logic [5:0]    root_reg;
    logic [VW-1:0] top_v_reg;
    logic [LW-1:0] top_c_reg;
    logic [VW-1:0] w_reg;
    logic [LW-1:0] nlink_reg;

    logic [5:0] cnt;
    logic [SW-1:0] top_idx;
    logic ok_add;
    logic [VW-1:0] s_i, t_i;
    logic w_ok;

    assign cnt = (vertex_count > 6'(MaxVertices)) ? 6'(MaxVertices) : vertex_count;
    assign top_idx = depth_reg - 1'b1;
    assign s_i = VW'(edge_source - 6'd1);
    assign t_i = VW'(edge_target - 6'd1);
    assign ok_add = edge_source >= 6'd1 && edge_source <= cnt && edge_target >= 6'd1
        && edge_target <= cnt && edge_total_reg < LW'(MaxEdges);
    assign w_ok = (6'(w_reg) < cnt) && !visited_reg[w_reg];

    assign sts.roots_done  = root_reg >= cnt;
    assign sts.root_white  = !visited_reg[VW'(root_reg)];
    assign sts.stack_empty = depth_reg == '0;
    assign sts.emits       = top_c_reg[EW] || w_ok;
    assign scan_count      = scan_reg;

    // edge memories, read at cursor of top of stack
    always_ff @(posedge aclk) begin
        if (cmd.add_edge && ok_add) begin
            dest_mem[edge_total_reg[EW-1:0]] <= t_i;
            link_mem[edge_total_reg[EW-1:0]] <= LW'(MaxEdges);
            if (!head_reg[s_i][EW])
                link_mem[tail_reg[s_i]] <= edge_total_reg;
        end
        if (cmd.read_top) begin
            w_reg     <= dest_mem[stk_c_reg[VW'(top_idx)][EW-1:0]];
            nlink_reg <= link_mem[stk_c_reg[VW'(top_idx)][EW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.read_top) begin
            top_v_reg <= stk_v_reg[VW'(top_idx)];
            top_c_reg <= stk_c_reg[VW'(top_idx)];
        end
        if (cmd.add_edge && ok_add)
            tail_reg[s_i] <= edge_total_reg[EW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid <= 1'b0;
            edge_total_reg <= '0;
            depth_reg <= '0;
            time_reg <= '0;
            scan_reg <= '0;
            root_reg <= '0;
            visited_reg <= '0;
            for (int i = 0; i < MaxVertices; i++) head_reg[i] <= LW'(MaxEdges);
        end else begin
            res_valid <= cmd.load_root || (cmd.step && sts.emits);
            if (cmd.clear_graph) begin
                edge_total_reg <= '0;
                for (int i = 0; i < MaxVertices; i++) head_reg[i] <= LW'(MaxEdges);
            end
            if (cmd.add_edge && ok_add) begin
                edge_total_reg <= edge_total_reg + 1'b1;
                if (head_reg[s_i][EW]) head_reg[s_i] <= edge_total_reg;
            end
            if (cmd.run_init) begin
                visited_reg <= '0;
                time_reg <= '0;
                scan_reg <= '0;
                depth_reg <= '0;
                root_reg <= '0;
            end
            if (cmd.next_root) root_reg <= root_reg + 6'd1;
            if (cmd.load_root) begin
                time_reg <= time_reg + 7'd1;
                visited_reg[VW'(root_reg)] <= 1'b1;
                stk_v_reg[VW'(depth_reg)] <= VW'(root_reg);
                stk_c_reg[VW'(depth_reg)] <= head_reg[VW'(root_reg)];
                depth_reg <= depth_reg + 1'b1;
                res_kind <= 1'b0;
                res_vertex <= root_reg + 6'd1;
                res_stamp <= time_reg + 7'd1;
                res_root <= 1'b1;
            end
            if (cmd.step) begin
                if (top_c_reg[EW]) begin
                    depth_reg <= depth_reg - 1'b1;
                    time_reg <= time_reg + 7'd1;
                    res_kind <= 1'b1;
                    res_vertex <= 6'(top_v_reg) + 6'd1;
                    res_stamp <= time_reg + 7'd1;
                    res_root <= 1'b0;
                end else begin
                    stk_c_reg[VW'(top_idx)] <= nlink_reg;
                    scan_reg <= scan_reg + 7'd1;
                    if (w_ok) begin
                        time_reg <= time_reg + 7'd1;
                        visited_reg[w_reg] <= 1'b1;
                        // depth never exceeds vertex count, so push always fits
                        stk_v_reg[VW'(depth_reg)] <= w_reg;
                        stk_c_reg[VW'(depth_reg)] <= head_reg[w_reg];
                        depth_reg <= depth_reg + 1'b1;
                        res_kind <= 1'b0;
                        res_vertex <= 6'(w_reg) + 6'd1;
                        res_stamp <= time_reg + 7'd1;
                        res_root <= 1'b0;
                    end
                end
            end
        end
    end
endmodule

FILE: rtl/dfst_ctrl.sv
module dfst_ctrl
    import dfst_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_action,
    input  dfst_sts_t  sts,
    output dfst_cmd_t  cmd,
    input  logic       res_pending,  // a result is staged, not yet handed on
    output logic       run_done,     // pulse: run ended, flag last staged result
    output logic       run_active
);
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ROOT  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_STEP  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = state_reg == ST_IDLE;
    assign run_active = state_reg != ST_IDLE;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        run_done = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (action_t'(s_action))
                        ACT_ADD:   cmd.add_edge = 1'b1;
                        ACT_CLEAR: cmd.clear_graph = 1'b1;
                        ACT_RUN: begin
                            cmd.run_init = 1'b1;
                            state_next = ST_ROOT;
                        end
                        ACT_NONE: ;
                    endcase
                end
            end
            ST_ROOT: begin
                if (sts.roots_done) state_next = ST_DONE;
                else if (!sts.root_white) cmd.next_root = 1'b1;
                else if (!res_pending) begin
                    cmd.load_root = 1'b1;
                    cmd.next_root = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (sts.stack_empty) state_next = ST_ROOT;
                else begin
                    cmd.read_top = 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                if (!sts.emits || !res_pending) begin
                    cmd.step = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_DONE: begin
                // wait for the output register so the held result can move
                if (!res_pending) begin
                    run_done = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end
endmodule

FILE: rtl/dfst_outq.sv
module dfst_outq
    import dfst_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic       in_kind,
    input  logic [5:0] in_vertex,
    input  logic [6:0] in_stamp,
    input  logic       in_root,
    input  logic       run_done,
    input  logic [6:0] scan_count,
    output logic       pending,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_event_kind,
    output logic [5:0] m_vertex,
    output logic [6:0] m_stamp,
    output logic       m_tree_root,
    output logic [6:0] m_edges_examined,
    output logic       m_last
);
    // one held result waits until the next one or the end of run, so the
    // final result can be tagged last
    logic       hold_reg, hold_next;
    logic       m_valid_next;
    logic       h_kind_reg, h_root_reg;
    logic [5:0] h_vertex_reg;
    logic [6:0] h_stamp_reg;
    logic       move;

    assign pending = hold_reg && m_valid && !m_ready;
    assign move = hold_reg && (in_valid || run_done) && (!m_valid || m_ready);

    always_comb begin
        hold_next = hold_reg;
        if (move) hold_next = 1'b0;
        if (in_valid) hold_next = 1'b1;
        m_valid_next = m_valid;
        if (m_valid && m_ready) m_valid_next = 1'b0;
        if (move) m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= 1'b0;
            m_valid <= 1'b0;
        end else begin
            hold_reg <= hold_next;
            m_valid <= m_valid_next;
            if (move) begin
                m_event_kind <= h_kind_reg;
                m_vertex <= h_vertex_reg;
                m_stamp <= h_stamp_reg;
                m_tree_root <= h_root_reg;
                m_last <= run_done;
                m_edges_examined <= run_done ? scan_count : 7'd0;
            end
            if (in_valid) begin
                h_kind_reg <= in_kind;
                h_vertex_reg <= in_vertex;
                h_stamp_reg <= in_stamp;
                h_root_reg <= in_root;
            end
        end
    end
endmodule

FILE: rtl/depth_first_search_timestamps_unit.sv
// channel | ports                                   | direction
// s_      | s_valid s_ready s_action s_edge_*       | request in
// m_      | m_valid m_ready m_event_kind ... m_last | result out
// cfg_    | cfg_valid cfg_ready cfg_vertex_count    | register write
// add and clear requests are taken while idle; a run tries each root in
// turn, starts a search tree at each unvisited one, and for each stack
// step (an edge scanned or a finish) reads the top of stack, then acts on it
// results wait for the next one or run end to carry last and edges_examined
// reset: synchronous active low, graph emptied, vertex_count = 1
// stalls on m_ready pause the search before a result is produced
module depth_first_search_timestamps_unit
    import dfst_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [5:0] cfg_vertex_count,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_action,
    input  logic [5:0] s_edge_source,
    input  logic [5:0] s_edge_target,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_event_kind,
    output logic [5:0] m_vertex,
    output logic [6:0] m_stamp,
    output logic       m_tree_root,
    output logic [6:0] m_edges_examined,
    output logic       m_last
);
    dfst_cmd_t cmd;
    dfst_sts_t sts;
    logic [5:0] vcount_reg;
    logic res_valid, res_kind, res_root, pending, run_done, run_active;
    logic [5:0] res_vertex;
    logic [6:0] res_stamp, scan_count;

    // register write always taken
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) vcount_reg <= 6'd1;
        else if (cfg_valid) vcount_reg <= cfg_vertex_count;
    end

    dfst_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_action, .sts, .cmd,
        .res_pending(pending || (m_valid && !m_ready)), .run_done, .run_active
    );

    dfst_datapath u_dp (
        .aclk, .aresetn, .cmd, .sts, .vertex_count(vcount_reg),
        .edge_source(s_edge_source), .edge_target(s_edge_target),
        .res_valid, .res_kind, .res_vertex, .res_stamp, .res_root, .scan_count
    );

    dfst_outq u_outq (
        .aclk, .aresetn, .in_valid(res_valid), .in_kind(res_kind),
        .in_vertex(res_vertex), .in_stamp(res_stamp), .in_root(res_root),
        .run_done(run_done && run_active), .scan_count, .pending,
        .m_valid, .m_ready, .m_event_kind, .m_vertex, .m_stamp, .m_tree_root,
        .m_edges_examined, .m_last
    );
endmodule

FILE: rtl/dfst_checker.sv
module dfst_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_event_kind,
    input logic       m_tree_root,
    input logic [6:0] m_edges_examined,
    input logic       m_last
);
    a_root_disc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tree_root |-> !m_event_kind) else $error("root on finish");
    a_last_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_event_kind) else $error("last not a finish");
    a_scan_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> m_edges_examined == 7'd0) else $error("count early");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    a_req_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid) else $error("request dropped");
endmodule

bind depth_first_search_timestamps_unit dfst_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_event_kind,
    .m_tree_root, .m_edges_examined, .m_last
);
